/* design/mux_adc_scan_accumulator_assert.svh */
// Assertion macros for the scan accumulator checker.
`ifndef MUX_ADC_SCAN_ACCUMULATOR_ASSERT_SVH
`define MUX_ADC_SCAN_ACCUMULATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MAS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mas: property failed");

// antecedent implies consequent in the next cycle
`define MAS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mas: property failed");

// antecedent implies a delayed consequent
`define MAS_ASSERT_DLY2(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("mas: property failed");

`endif

/* design/mas_pkg.sv */
package mas_pkg;

	localparam int INPUTS_PER_MUX = 16;
	localparam int MUX_COUNT      = 2;

	localparam int IDX_W    = (INPUTS_PER_MUX > 1) ? $clog2(INPUTS_PER_MUX) : 1;
	localparam int SLOT_W   = 5;
	localparam int SLOTS    = 1 << SLOT_W;
	localparam int ACC_W    = 15;
	localparam int SAMPLE_W = 10;
	localparam int PASS_W   = 6;
	localparam int SEL_W    = 4;
	localparam int CHAN_W   = 4;
	localparam int SHIFT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	localparam logic [1:0] REQ_CONV    = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHMAP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd3;

	localparam logic [63:0]        ORDER_RST  = 64'hFEDC_BA98_7654_3210;
	localparam logic [7:0]         CHMAP_RST  = 8'h10;
	localparam logic [PASS_W-1:0]  TARGET_RST = 6'd16;
	localparam logic [SHIFT_W-1:0] SHIFT_RST  = 3'd4;

	typedef struct packed {
		logic                conv;
		logic                clr;
		logic [SLOT_W-1:0]   slot;
		logic [SAMPLE_W-1:0] sample;
		logic [SEL_W-1:0]    mux_select;
		logic [CHAN_W-1:0]   adc_channel;
		logic                data_ready;
	} op_t;

endpackage

/* design/mas_scan.sv */
module mas_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [mas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mas_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              accept,
	input  logic [1:0]                        req_type,
	input  logic [mas_pkg::SAMPLE_W-1:0]      sample,
	input  logic [mas_pkg::SLOT_W-1:0]        channel_id,
	output mas_pkg::op_t                      op,
	output logic [mas_pkg::SHIFT_W-1:0]       shift
);

	logic [63:0]                     order_q;
	logic [7:0]                      chmap_q;
	logic [mas_pkg::PASS_W-1:0]      target_q;
	logic [mas_pkg::SHIFT_W-1:0]     shift_q;
	logic [mas_pkg::IDX_W-1:0]       pos_q, pos_n;
	logic                            mux_q, mux_n;
	logic [mas_pkg::PASS_W-1:0]      pass_q, pass_n;
	logic                            full, conv, restart;
	logic [3:0]                      pos_x;
	logic [5:0]                      bit_lo;
	logic [mas_pkg::SLOT_W-1:0]      scan_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= mas_pkg::ORDER_RST;
			chmap_q  <= mas_pkg::CHMAP_RST;
			target_q <= mas_pkg::TARGET_RST;
			shift_q  <= mas_pkg::SHIFT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mas_pkg::CFG_ORDER:  order_q  <= cfg_data;
				mas_pkg::CFG_CHMAP:  chmap_q  <= cfg_data[7:0];
				mas_pkg::CFG_TARGET: target_q <= cfg_data[mas_pkg::PASS_W-1:0];
				mas_pkg::CFG_SHIFT:  shift_q  <= cfg_data[mas_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		full      = pass_q >= target_q;
		conv      = (req_type == mas_pkg::REQ_CONV) && !full;
		restart   = req_type == mas_pkg::REQ_RESTART;
		scan_slot = mas_pkg::SLOT_W'(mux_q) * mas_pkg::SLOT_W'(mas_pkg::INPUTS_PER_MUX)
			+ mas_pkg::SLOT_W'(pos_q);
		pos_n  = pos_q;
		mux_n  = mux_q;
		pass_n = pass_q;
		if (restart) begin
			pos_n  = '0;
			mux_n  = 1'b0;
			pass_n = '0;
		end else if (conv) begin
			if (pos_q == mas_pkg::IDX_W'(mas_pkg::INPUTS_PER_MUX - 1)) begin
				pos_n = '0;
				if (mux_q == 1'(mas_pkg::MUX_COUNT - 1)) begin
					mux_n  = 1'b0;
					pass_n = pass_q + 1'b1;
				end else begin
					mux_n = mux_q + 1'b1;
				end
			end else begin
				pos_n = pos_q + 1'b1;
			end
		end
		pos_x  = 4'(pos_n);
		bit_lo = {pos_x, 2'b00};

		op.conv        = conv;
		op.clr         = req_type == mas_pkg::REQ_READ;
		op.slot        = op.clr ? channel_id : scan_slot;
		op.sample      = sample;
		op.mux_select  = order_q[bit_lo +: mas_pkg::SEL_W];
		op.adc_channel = mux_n ? chmap_q[7:4] : chmap_q[3:0];
		op.data_ready  = pass_n >= target_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mux_q  <= 1'b0;
			pass_q <= '0;
		end else if (accept) begin
			pos_q  <= pos_n;
			mux_q  <= mux_n;
			pass_q <= pass_n;
		end
	end

	assign shift = shift_q;

endmodule

/* design/mas_acc.sv */
module mas_acc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  mas_pkg::op_t                  op,
	input  logic [mas_pkg::SHIFT_W-1:0]   shift,
	output logic                          busy,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [mas_pkg::SEL_W-1:0]     mux_select,
	output logic [mas_pkg::CHAN_W-1:0]    adc_channel,
	output logic [mas_pkg::ACC_W-1:0]     value,
	output logic                          data_ready
);

	logic [mas_pkg::ACC_W-1:0]  mem [mas_pkg::SLOTS];
	logic [mas_pkg::SLOTS-1:0]  vld_q;

	logic                       v_s1;
	mas_pkg::op_t               op_s1;
	logic [mas_pkg::ACC_W-1:0]  rdata_s1;
	logic                       vld_s1;
	logic                       fwd_s1;
	logic [mas_pkg::ACC_W-1:0]  fwd_data_s1;

	logic                       advance, wr_en;
	logic [mas_pkg::ACC_W-1:0]  old, wr_data, val;
	logic [mas_pkg::ACC_W:0]    sum;

	logic                       rsp_v_q;
	logic [mas_pkg::SEL_W-1:0]  sel_q;
	logic [mas_pkg::CHAN_W-1:0] chan_q;
	logic [mas_pkg::ACC_W-1:0]  value_q;
	logic                       ready_q;

	always_comb begin
		advance = v_s1 && !(rsp_v_q && rsp_stall);
		busy    = v_s1 && !advance;
		wr_en   = advance && (op_s1.conv || op_s1.clr);
		old     = fwd_s1 ? fwd_data_s1 : (vld_s1 ? rdata_s1 : '0);
		sum     = {1'b0, old} + (mas_pkg::ACC_W + 1)'(op_s1.sample);
		if (op_s1.clr) begin
			wr_data = '0;
			val     = old >> shift;
		end else begin
			wr_data = sum[mas_pkg::ACC_W] ? mas_pkg::ACC_MAX : sum[mas_pkg::ACC_W-1:0];
			val     = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[op_s1.slot] <= wr_data;
		if (accept)
			rdata_s1 <= mem[op.slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[op_s1.slot] <= 1'b1;
		end
	end

	// read-modify-write stage; forward the write that lands with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			vld_s1      <= vld_q[op.slot];
			fwd_s1      <= wr_en && (op_s1.slot == op.slot);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sel_q   <= op_s1.mux_select;
			chan_q  <= op_s1.adc_channel;
			value_q <= val;
			ready_q <= op_s1.data_ready;
		end
	end

	assign rsp_valid   = rsp_v_q;
	assign mux_select  = sel_q;
	assign adc_channel = chan_q;
	assign value       = value_q;
	assign data_ready  = ready_q;

endmodule

/* design/mux_adc_scan_accumulator.sv */
// channel | handshake              | transfer carries
// req     | req_valid / req_stall  | req_type, sample, channel_id
// rsp     | rsp_valid / rsp_stall  | mux_select, adc_channel, value, data_ready
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while req_stall is low; its response passes through the accumulator
// RAM read stage and then the response register.
// Scan position and pass count update at request transfer; the RAM write lands when the request leaves the read stage.
// req_stall rises only while a response is held by rsp_stall with another behind it.
// Reset clears scan state, accumulator valid bits and loads register defaults.
module mux_adc_scan_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        req_type,
	input  logic [mas_pkg::SAMPLE_W-1:0]      sample,
	input  logic [mas_pkg::SLOT_W-1:0]        channel_id,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [mas_pkg::SEL_W-1:0]         mux_select,
	output logic [mas_pkg::CHAN_W-1:0]        adc_channel,
	output logic [mas_pkg::ACC_W-1:0]         value,
	output logic                              data_ready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mas_pkg::CFG_DATA_W-1:0]    cfg_data
);

	mas_pkg::op_t                  op;
	logic [mas_pkg::SHIFT_W-1:0]   shift;
	logic                          busy;
	logic                          accept;

	assign req_stall = busy;
	assign accept    = req_valid && !busy;
	assign cfg_ready = 1'b1;

	mas_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.req_type   (req_type),
		.sample     (sample),
		.channel_id (channel_id),
		.op         (op),
		.shift      (shift)
	);

	mas_acc u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.shift       (shift),
		.busy        (busy),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.mux_select  (mux_select),
		.adc_channel (adc_channel),
		.value       (value),
		.data_ready  (data_ready)
	);

endmodule

/* design/mas_checker.sv */
`include "mux_adc_scan_accumulator_assert.svh"

module mas_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [mas_pkg::SEL_W-1:0]     mux_select,
	input logic [mas_pkg::ACC_W-1:0]     value
);

	`MAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(value) && $stable(mux_select))
	`MAS_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall)
	`MAS_ASSERT_DLY2(a_rsp_latency, req_valid && !req_stall, rsp_valid)

endmodule

bind mux_adc_scan_accumulator mas_checker u_mas_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.mux_select (mux_select),
	.value      (value)
);
